/* design/nearest_point_on_circle_macros.svh */
// Assertion helpers shared by the nearest point on circle RTL.
`ifndef NEAREST_POINT_ON_CIRCLE_MACROS_SVH
`define NEAREST_POINT_ON_CIRCLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define NPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/npc_pkg.sv */
package npc_pkg;

    localparam int COORD_WIDTH_DEF = 24;

    // Per-stage control that rides alongside the arithmetic.
    typedef struct packed {
        logic vld;
        logic zero;
        logic neg_x;
        logic neg_y;
    } t_ctrl;

endpackage

/* design/nearest_point_on_circle.sv */
// Nearest point on a circle.
// Input channel (i_valid / o_ready) carries a centre, an old point and a radius
// in signed fixed point; output channel (o_valid / i_ready) returns the point
// on the circle nearest the old point, rounded per axis and saturated.
// Coincident points return the centre moved left by the radius.
// The fraction width does not affect the logic: all operands share one scale.
// Throughput: one transfer per cycle while the output is not stalled. Data
// passes through the prep registers for squaring and products, one search
// cell per result bit in each axis chain, and the output register.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so o_ready drops only while a result waits and i_ready is
// low; nothing is lost or repeated across a stall.
// Reset (synchronous, active low) empties the pipeline; only control is reset.
`include "nearest_point_on_circle_macros.svh"

module nearest_point_on_circle #(
    parameter int COORD_WIDTH = npc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_old_x,
    input  logic signed [COORD_WIDTH-1:0] i_old_y,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_new_x,
    output logic signed [COORD_WIDTH-1:0] o_new_y
);
    localparam int W = COORD_WIDTH;

    logic en;

    wire npc_pkg::t_ctrl      ctl_w [0:W];
    wire logic signed [W-1:0] cx_w  [0:W];
    wire logic signed [W-1:0] cy_w  [0:W];
    wire logic [W-2:0]        rad_w [0:W];
    wire logic [4*W-1:0]      resx_w [0:W];
    wire logic [4*W-1:0]      resy_w [0:W];
    wire logic [W-1:0]        kx_w [0:W];
    wire logic [W-1:0]        ky_w [0:W];
    wire logic [3*W:0]        ksx_w [0:W];
    wire logic [3*W:0]        ksy_w [0:W];
    wire logic [2*W:0]        sx_w [0:W];
    wire logic [2*W:0]        sy_w [0:W];
    logic [2*W:0]             s_prep;

    logic                     r_o_valid, r_zero_o;
    logic signed [W-1:0]      r_new_x, r_new_y, r_cy_o;
    logic [W:0]               n_kx1, n_ky1;
    logic [W-1:0]             n_mx, n_my;
    logic signed [W+1:0]      n_sum_x, n_sum_y;
    logic signed [W-1:0]      n_sat_x, n_sat_y;

    localparam logic signed [W+1:0] SatHi = (W+2)'((64'd1 << (W - 1)) - 64'd1);
    localparam logic signed [W+1:0] SatLo = -SatHi - (W+2)'(1);

    assign en      = !r_o_valid || i_ready;
    assign o_ready = en;

    npc_prep #(.COORD_WIDTH(W)) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_valid),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_old_x    (i_old_x),
        .i_old_y    (i_old_y),
        .i_radius   (i_radius),
        .o_ctrl     (ctl_w[0]),
        .o_cx       (cx_w[0]),
        .o_cy       (cy_w[0]),
        .o_rad      (rad_w[0]),
        .o_s        (s_prep),
        .o_nx       (resx_w[0]),
        .o_ny       (resy_w[0])
    );

    assign sx_w[0]  = s_prep;
    assign sy_w[0]  = s_prep;
    assign kx_w[0]  = '0;
    assign ky_w[0]  = '0;
    assign ksx_w[0] = '0;
    assign ksy_w[0] = '0;

    for (genvar g = 0; g < W; g++) begin : g_stage
        npc_pkg::t_ctrl      r_ctl;
        logic signed [W-1:0] r_cx, r_cy;
        logic [W-2:0]        r_rad;

        npc_cell #(.COORD_WIDTH(W), .BIT(W - 1 - g)) u_cell_x (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (ctl_w[g].vld),
            .i_res   (resx_w[g]),
            .i_k     (kx_w[g]),
            .i_ks    (ksx_w[g]),
            .i_s     (sx_w[g]),
            .o_res   (resx_w[g+1]),
            .o_k     (kx_w[g+1]),
            .o_ks    (ksx_w[g+1]),
            .o_s     (sx_w[g+1])
        );

        npc_cell #(.COORD_WIDTH(W), .BIT(W - 1 - g)) u_cell_y (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (ctl_w[g].vld),
            .i_res   (resy_w[g]),
            .i_k     (ky_w[g]),
            .i_ks    (ksy_w[g]),
            .i_s     (sy_w[g]),
            .o_res   (resy_w[g+1]),
            .o_k     (ky_w[g+1]),
            .o_ks    (ksy_w[g+1]),
            .o_s     (sy_w[g+1])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl <= '0;
            end else if (en) begin
                r_ctl <= ctl_w[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx  <= cx_w[g];
                r_cy  <= cy_w[g];
                r_rad <= rad_w[g];
            end
        end

        assign ctl_w[g+1] = r_ctl;
        assign cx_w[g+1]  = r_cx;
        assign cy_w[g+1]  = r_cy;
        assign rad_w[g+1] = r_rad;
    end

    // largest k with k^2 S <= N; the rounded magnitude is (k + 1) / 2
    always_comb begin
        n_kx1 = (W+1)'(kx_w[W]) + (W+1)'(1);
        n_ky1 = (W+1)'(ky_w[W]) + (W+1)'(1);
        n_mx  = n_kx1[W:1];
        n_my  = n_ky1[W:1];
        if (ctl_w[W].zero) begin
            n_sum_x = (W+2)'(cx_w[W]) - $signed((W+2)'(rad_w[W]));
            n_sum_y = (W+2)'(cy_w[W]);
        end else begin
            n_sum_x = ctl_w[W].neg_x ? (W+2)'(cx_w[W]) - $signed((W+2)'(n_mx))
                                     : (W+2)'(cx_w[W]) + $signed((W+2)'(n_mx));
            n_sum_y = ctl_w[W].neg_y ? (W+2)'(cy_w[W]) - $signed((W+2)'(n_my))
                                     : (W+2)'(cy_w[W]) + $signed((W+2)'(n_my));
        end
        if (n_sum_x > SatHi) begin
            n_sat_x = SatHi[W-1:0];
        end else if (n_sum_x < SatLo) begin
            n_sat_x = SatLo[W-1:0];
        end else begin
            n_sat_x = n_sum_x[W-1:0];
        end
        if (n_sum_y > SatHi) begin
            n_sat_y = SatHi[W-1:0];
        end else if (n_sum_y < SatLo) begin
            n_sat_y = SatLo[W-1:0];
        end else begin
            n_sat_y = n_sum_y[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= ctl_w[W].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_new_x  <= n_sat_x;
            r_new_y  <= n_sat_y;
            r_zero_o <= ctl_w[W].zero;
            r_cy_o   <= cy_w[W];
        end
    end

    assign o_valid = r_o_valid;
    assign o_new_x = r_new_x;
    assign o_new_y = r_new_y;

    `NPC_ASSERT_IMP(a_coincident_keeps_y, i_clk, i_rst_n, r_o_valid && r_zero_o, o_new_y == r_cy_o)

endmodule

/* design/npc_prep.sv */
module npc_prep #(
    parameter int COORD_WIDTH = npc_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic signed [COORD_WIDTH-1:0] i_old_x,
    input  logic signed [COORD_WIDTH-1:0] i_old_y,
    input  logic        [COORD_WIDTH-2:0] i_radius,
    output npc_pkg::t_ctrl                o_ctrl,
    output logic signed [COORD_WIDTH-1:0] o_cx,
    output logic signed [COORD_WIDTH-1:0] o_cy,
    output logic        [COORD_WIDTH-2:0] o_rad,
    output logic        [2*COORD_WIDTH:0] o_s,
    output logic      [4*COORD_WIDTH-1:0] o_nx,
    output logic      [4*COORD_WIDTH-1:0] o_ny
);
    localparam int W = COORD_WIDTH;

    // stage 1 logic
    logic signed [W:0]   n_dx, n_dy;
    logic        [W:0]   n_ndx, n_ndy;
    npc_pkg::t_ctrl      n_c1;
    // stage registers
    npc_pkg::t_ctrl      r_c1, r_c2, r_c3, r_c4;
    logic [W-1:0]        r_ax1, r_ay1;
    logic signed [W-1:0] r_cx1, r_cy1, r_cx2, r_cy2, r_cx3, r_cy3, r_cx4, r_cy4;
    logic [W-2:0]        r_rad1, r_rad2, r_rad3, r_rad4;
    logic [2*W-1:0]      r_sqx2, r_sqy2;
    logic [2*W-2:0]      r_px2, r_py2;
    logic [2*W:0]        r_s3, r_s4;
    logic [2*W-1:0]      r_hhx3, r_hlx3, r_llx3, r_hhy3, r_hly3, r_lly3;
    logic [4*W-1:0]      r_nx4, r_ny4;
    logic [2*W-1:0]      n_sqx, n_sqy, n_px_full, n_py_full;
    logic [2*W-1:0]      n_pxs, n_pys;
    logic [2*W-1:0]      n_hhx, n_hlx, n_llx, n_hhy, n_hly, n_lly;

    always_comb begin
        n_dx  = {i_old_x[W-1], i_old_x} - {i_center_x[W-1], i_center_x};
        n_dy  = {i_old_y[W-1], i_old_y} - {i_center_y[W-1], i_center_y};
        n_ndx = -n_dx;
        n_ndy = -n_dy;
        n_c1.vld   = i_vld;
        n_c1.zero  = (n_dx == '0) && (n_dy == '0);
        n_c1.neg_x = n_dx[W];
        n_c1.neg_y = n_dy[W];
    end

    assign n_sqx     = (2*W)'(r_ax1) * (2*W)'(r_ax1);
    assign n_sqy     = (2*W)'(r_ay1) * (2*W)'(r_ay1);
    assign n_px_full = (2*W)'(r_rad1) * (2*W)'(r_ax1);
    assign n_py_full = (2*W)'(r_rad1) * (2*W)'(r_ay1);

    // P = 2*r*d, squared from W-bit halves
    assign n_pxs = {r_px2, 1'b0};
    assign n_pys = {r_py2, 1'b0};
    assign n_hhx = (2*W)'(n_pxs[2*W-1:W]) * (2*W)'(n_pxs[2*W-1:W]);
    assign n_hlx = (2*W)'(n_pxs[2*W-1:W]) * (2*W)'(n_pxs[W-1:0]);
    assign n_llx = (2*W)'(n_pxs[W-1:0])   * (2*W)'(n_pxs[W-1:0]);
    assign n_hhy = (2*W)'(n_pys[2*W-1:W]) * (2*W)'(n_pys[2*W-1:W]);
    assign n_hly = (2*W)'(n_pys[2*W-1:W]) * (2*W)'(n_pys[W-1:0]);
    assign n_lly = (2*W)'(n_pys[W-1:0])   * (2*W)'(n_pys[W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
        end else if (i_en) begin
            r_c1 <= n_c1;
            r_c2 <= r_c1;
            r_c3 <= r_c2;
            r_c4 <= r_c3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1  <= n_dx[W] ? n_ndx[W-1:0] : n_dx[W-1:0];
            r_ay1  <= n_dy[W] ? n_ndy[W-1:0] : n_dy[W-1:0];
            r_cx1  <= i_center_x;
            r_cy1  <= i_center_y;
            r_rad1 <= i_radius;

            r_sqx2 <= n_sqx;
            r_sqy2 <= n_sqy;
            r_px2  <= n_px_full[2*W-2:0];
            r_py2  <= n_py_full[2*W-2:0];
            r_cx2  <= r_cx1;
            r_cy2  <= r_cy1;
            r_rad2 <= r_rad1;

            r_s3   <= (2*W+1)'(r_sqx2) + (2*W+1)'(r_sqy2);
            r_hhx3 <= n_hhx;
            r_hlx3 <= n_hlx;
            r_llx3 <= n_llx;
            r_hhy3 <= n_hhy;
            r_hly3 <= n_hly;
            r_lly3 <= n_lly;
            r_cx3  <= r_cx2;
            r_cy3  <= r_cy2;
            r_rad3 <= r_rad2;

            r_s4   <= r_s3;
            r_nx4  <= ((4*W)'(r_hhx3) << (2*W)) + ((4*W)'(r_hlx3) << (W+1))
                      + (4*W)'(r_llx3);
            r_ny4  <= ((4*W)'(r_hhy3) << (2*W)) + ((4*W)'(r_hly3) << (W+1))
                      + (4*W)'(r_lly3);
            r_cx4  <= r_cx3;
            r_cy4  <= r_cy3;
            r_rad4 <= r_rad3;
        end
    end

    assign o_ctrl = r_c4;
    assign o_cx   = r_cx4;
    assign o_cy   = r_cy4;
    assign o_rad  = r_rad4;
    assign o_s    = r_s4;
    assign o_nx   = r_nx4;
    assign o_ny   = r_ny4;

endmodule

/* design/npc_cell.sv */
`include "nearest_point_on_circle_macros.svh"

// One step of the root search: try setting bit BIT of k while k^2*S <= N.
module npc_cell #(
    parameter int COORD_WIDTH = npc_pkg::COORD_WIDTH_DEF,
    parameter int BIT         = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [4*COORD_WIDTH-1:0] i_res,
    input  logic [COORD_WIDTH-1:0]   i_k,
    input  logic [3*COORD_WIDTH:0]   i_ks,
    input  logic [2*COORD_WIDTH:0]   i_s,
    output logic [4*COORD_WIDTH-1:0] o_res,
    output logic [COORD_WIDTH-1:0]   o_k,
    output logic [3*COORD_WIDTH:0]   o_ks,
    output logic [2*COORD_WIDTH:0]   o_s
);
    localparam int W  = COORD_WIDTH;
    localparam int TW = 4*W + 2;

    logic [TW-1:0]  n_term;
    logic           n_take;
    logic [4*W-1:0] r_res;
    logic [W-1:0]   r_k;
    logic [3*W:0]   r_ks;
    logic [2*W:0]   r_s;

    // (k + 2^j)^2 S - k^2 S = 2^(j+1) kS + 2^(2j) S
    always_comb begin
        n_term = (TW'(i_ks) << (BIT + 1)) + (TW'(i_s) << (2 * BIT));
        n_take = n_term <= TW'(i_res);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= i_s;
            if (n_take) begin
                r_res <= i_res - n_term[4*W-1:0];
                r_k   <= i_k | (W'(1) << BIT);
                r_ks  <= i_ks + ((3*W+1)'(i_s) << BIT);
            end else begin
                r_res <= i_res;
                r_k   <= i_k;
                r_ks  <= i_ks;
            end
        end
    end

    assign o_res = r_res;
    assign o_k   = r_k;
    assign o_ks  = r_ks;
    assign o_s   = r_s;

    `NPC_ASSERT_NXT(a_res_never_grows, i_clk, i_rst_n, i_en && i_vld, r_res <= $past(i_res))
    `NPC_ASSERT_NXT(a_upper_bits_kept, i_clk, i_rst_n, i_en && i_vld, (r_k >> (BIT + 1)) == ($past(i_k) >> (BIT + 1)))

endmodule

/* tb/sv/nearest_point_on_circle_tb.sv */
module nearest_point_on_circle_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W          = npc_pkg::COORD_WIDTH_DEF;
    localparam int N_RANDOM   = 1500;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN      = 40;
    localparam longint CMAX   = (64'sd1 <<< (W - 1)) - 1;
    localparam longint CMIN   = -(64'sd1 <<< (W - 1));
    localparam logic signed [W-1:0] XMAX = CMAX[W-1:0];
    localparam logic signed [W-1:0] XMIN = CMIN[W-1:0];
    localparam logic        [W-2:0] RMAX = CMAX[W-2:0];

    typedef struct {
        logic signed [W-1:0] cx, cy, ox, oy;
        logic [W-2:0]        r;
        bit                  typed;
        logic signed [W-1:0] ex, ey;
    } t_row;

    typedef struct {
        logic signed [W-1:0] x, y;
    } t_point;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic signed [W-1:0] i_center_x, i_center_y, i_old_x, i_old_y;
    logic        [W-2:0] i_radius;
    logic                o_valid;
    logic                i_ready;
    logic signed [W-1:0] o_new_x, o_new_y;

    t_point point_q[$];
    t_row   table_q[$];
    bit     failed;
    bit     burst;
    int     idle_cycles;

    nearest_point_on_circle dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_old_x    (i_old_x),
        .i_old_y    (i_old_y),
        .i_radius   (i_radius),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_new_x    (o_new_x),
        .o_new_y    (o_new_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Largest m with (2m-1)^2 * len2 <= 4 r^2 d^2, i.e. round(r*d/L), ties away from zero.
    function automatic longint unsigned offset_mag(longint unsigned r, longint unsigned d,
                                                    logic [127:0] len2);
        logic [127:0]    rhs;
        logic [127:0]    lhs;
        longint unsigned lo, hi, mid;
        rhs = 128'(r) * 128'(r) * 128'(d) * 128'(d) * 128'd4;
        lo = 0;
        hi = r;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            lhs = 128'(2 * mid - 1);
            lhs = lhs * lhs * len2;
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic logic signed [W-1:0] clamp(longint v);
        if (v > CMAX) v = CMAX;
        if (v < CMIN) v = CMIN;
        return v[W-1:0];
    endfunction

    function automatic t_point project(logic signed [W-1:0] cx, logic signed [W-1:0] cy,
                                       logic signed [W-1:0] ox, logic signed [W-1:0] oy,
                                       logic [W-2:0] r);
        t_point          p;
        longint          dx, dy;
        longint unsigned ax, ay, mx, my;
        logic [127:0]    len2;
        dx = longint'(ox) - longint'(cx);
        dy = longint'(oy) - longint'(cy);
        if (dx == 0 && dy == 0) begin
            p.x = clamp(longint'(cx) - longint'(r));
            p.y = cy;
            return p;
        end
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        len2 = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
        mx = offset_mag(r, ax, len2);
        my = offset_mag(r, ay, len2);
        p.x = clamp((dx < 0) ? longint'(cx) - longint'(mx) : longint'(cx) + longint'(mx));
        p.y = clamp((dy < 0) ? longint'(cy) - longint'(my) : longint'(cy) + longint'(my));
        return p;
    endfunction

    function automatic void add_row(t_row row);
        table_q.insert(table_q.size(), row);
    endfunction

    function automatic int draw_gap();
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic send_point(t_row row);
        t_point p;
        int     gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_center_x <= row.cx;
        i_center_y <= row.cy;
        i_old_x    <= row.ox;
        i_old_y    <= row.oy;
        i_radius   <= row.r;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (row.typed) begin
            p.x = row.ex;
            p.y = row.ey;
        end else begin
            p = project(row.cx, row.cy, row.ox, row.oy, row.r);
        end
        point_q.insert(point_q.size(), p);
        @(negedge i_clk);
    endtask

    function automatic t_row random_row();
        t_row row;
        int   kind;
        row.typed = 1'b0;
        row.cx = W'($urandom);
        row.cy = W'($urandom);
        row.r  = ($urandom_range(0, 3) == 0) ? (W-1)'($urandom_range(0, 4095))
                                             : (W-1)'($urandom);
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                row.ox = row.cx;
                row.oy = row.cy;
            end
            1: begin
                row.ox = row.cx;
                row.oy = W'($urandom);
            end
            2: begin
                row.ox = W'($urandom);
                row.oy = row.cy;
            end
            3, 4: begin
                row.ox = row.cx + $signed(W'($urandom_range(0, 64))) - $signed(W'(32));
                row.oy = row.cy + $signed(W'($urandom_range(0, 64))) - $signed(W'(32));
            end
            default: begin
                row.ox = W'($urandom);
                row.oy = W'($urandom);
            end
        endcase
        return row;
    endfunction

    // stimulus
    initial begin
        t_row row;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_center_x = '0;
        i_center_y = '0;
        i_old_x    = '0;
        i_old_y    = '0;
        i_radius   = '0;
        failed     = 1'b0;
        burst      = 1'b0;

        //       cx        cy        ox        oy        r     typed ex        ey
        add_row('{0, 0, 0, 0, 0, 1, 0, 0});
        add_row('{0, 0, 0, 0, 100, 1, -100, 0});
        add_row('{XMIN, XMIN, XMIN, XMIN, RMAX, 1, XMIN, XMIN});
        add_row('{XMAX, XMAX, XMAX, XMAX, 0, 1, XMAX, XMAX});
        add_row('{0, 0, 0, 5, 256, 1, 0, 256});
        add_row('{0, 0, 0, -5, 256, 1, 0, -256});
        add_row('{0, 0, 7, 0, 256, 1, 256, 0});
        add_row('{0, 0, -7, 0, 256, 1, -256, 0});
        add_row('{0, 0, 3, 4, 500, 1, 300, 400});
        add_row('{0, 0, -3, -4, 500, 1, -300, -400});
        add_row('{8388000, 0, XMAX, 0, RMAX, 1, XMAX, 0});
        add_row('{-8388000, 0, XMIN, 0, RMAX, 1, XMIN, 0});
        add_row('{0, 8388000, 0, XMAX, RMAX, 1, 0, XMAX});
        add_row('{0, -8388000, 0, XMIN, RMAX, 1, 0, XMIN});
        add_row('{XMIN, XMIN, XMAX, XMAX, RMAX, 0, 0, 0});
        add_row('{XMAX, XMAX, XMIN, XMIN, RMAX, 0, 0, 0});
        add_row('{XMIN, XMAX, XMAX, XMIN, RMAX, 0, 0, 0});
        add_row('{0, 0, 1, 1, 1, 0, 0, 0});
        add_row('{0, 0, 1, -1, 3, 0, 0, 0});
        add_row('{100, -100, 37, 91, 12345, 0, 0, 0});
        add_row('{-1, -1, -2, 5, 'h555555, 0, 0, 0});
        add_row('{'h2aaaaa, -'h2aaaab, -1, 0, 'h2aaaaa, 0, 0, 0});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_q[k]) send_point(table_q[k]);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 100) burst = ~burst;
            if (n == N_RANDOM / 2) begin
                // let the pipeline empty before carrying on
                i_valid <= 1'b0;
                wait (point_q.size() == 0);
                @(negedge i_clk);
            end
            row = random_row();
            send_point(row);
        end
        i_valid <= 1'b0;
        wait (point_q.size() == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (!failed && point_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random back-pressure
    initial begin
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (point_q.size() == 0) begin
                $error("result with no expectation: new_x=%0d new_y=%0d", o_new_x, o_new_y);
                failed = 1'b1;
            end else begin
                if (o_new_x !== point_q[0].x) begin
                    $error("new_x: expected %0d, got %0d", point_q[0].x, o_new_x);
                    failed = 1'b1;
                end
                if (o_new_y !== point_q[0].y) begin
                    $error("new_y: expected %0d, got %0d", point_q[0].y, o_new_y);
                    failed = 1'b1;
                end
                void'(point_q.pop_front());
            end
        end
    end

    // watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end
endmodule

/* files.f */
+incdir+design
design/npc_pkg.sv
design/npc_prep.sv
design/npc_cell.sv
design/nearest_point_on_circle.sv
tb/sv/nearest_point_on_circle_tb.sv
